// ----- rtl/core/wto_pkg.sv -----
// shared types, constants and rom helpers for the wavetable oscillator
package wto_pkg;

	localparam int TABLE_BITS_DEF  = 10;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int PHASE_BITS_DEF  = 32;

	localparam int CMD_W    = 2;
	localparam int FREQ_W   = 23;
	localparam int ENV_W    = 16;
	localparam int SCALE_W  = 24;
	localparam int MININC_W = 32;
	localparam int IN_W     = CMD_W + FREQ_W + ENV_W;
	localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_TICK        = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SET_FREQ    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RESET_PHASE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ENV_ENABLE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQUENCY   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQUENCY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INCREMENT_SCALE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INCREMENT   = 3'd5;

	typedef enum logic [1:0] {
		WAVE_SINE     = 2'd0,
		WAVE_TRIANGLE = 2'd1,
		WAVE_SAW      = 2'd2,
		WAVE_SQUARE   = 2'd3
	} wave_t;

	localparam wave_t                 WAVE_TYPE_RST       = WAVE_SINE;
	localparam logic                  ENV_ENABLE_RST      = 1'b1;
	localparam logic [FREQ_W-1:0]     MIN_FREQUENCY_RST   = 23'd5120;
	localparam logic [FREQ_W-1:0]     MAX_FREQUENCY_RST   = 23'd5120000;
	localparam logic [SCALE_W-1:0]    INCREMENT_SCALE_RST = 24'd97391;
	localparam logic [MININC_W-1:0]   MIN_INCREMENT_RST   = 32'd1947820;
	localparam longint unsigned       RESET_FREQ_Q8       = 64'd440 << 8;

	typedef struct packed {
		logic                 env_enable;
		logic [FREQ_W-1:0]    min_frequency;
		logic [FREQ_W-1:0]    max_frequency;
		logic [SCALE_W-1:0]   increment_scale;
		logic [MININC_W-1:0]  min_increment;
	} cfg_t;

	localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

	// (a*b) >> 62 on q62 operands
	function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// rounded magnitude of full-scale sine over the first quarter, r in [0, quarter]
	function automatic longint quarter_sine(input longint unsigned r, input int tbits,
			input int sbits);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] rnd;
		x = mul_q62(HALF_PI_Q62, 64'(r) << (64 - tbits));
		x2 = mul_q62(x, x);
		term = x;
		sum = x;
		for (int n = 1; n <= 14; n++) begin
			term = mul_q62(term, x2) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		rnd = (sum + (64'd1 << (62 - sbits))) >> (63 - sbits);
		return longint'(rnd);
	endfunction

endpackage

// ----- rtl/core/wavetable_oscillator_core.sv -----
// top level of the wavetable oscillator: configuration registers and stage wiring
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  cmd, frequency, env_level
// m_axis    out  m_axis_tvalid/m_axis_tready  sample (tick only)
// cfg       in   cfg_we                       cfg_index, cfg_data
//
// one item per cycle while no tick stalls; each tick yields one sample through the stages below
// stages: input register, phase and increment update into the index register,
// then sine rom or computed shape into the output register; no clearing pass
// reset loads phase 0 and the 440 Hz increment, register resets as listed
// a stalled output holds; set-frequency and reset-phase still go through
// while a sample waits, a tick stalls once both inner stages are full
module wavetable_oscillator_core import wto_pkg::*; #(
	parameter int TABLE_BITS  = TABLE_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [S_TDATA_W-1:0]                  s_axis_tdata,  // cmd, frequency, env_level
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata,  // sample
	input  logic                                  cfg_we,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [CFG_DATA_W-1:0]                 cfg_data
);

	localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

	wave_t                  wave_type_q;
	cfg_t                   cfg_q;
	logic                   idx_valid;
	logic                   idx_ready;
	logic [TABLE_BITS-1:0]  idx;
	logic [SAMPLE_BITS-1:0] sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_type_q           <= WAVE_TYPE_RST;
			cfg_q.env_enable      <= ENV_ENABLE_RST;
			cfg_q.min_frequency   <= MIN_FREQUENCY_RST;
			cfg_q.max_frequency   <= MAX_FREQUENCY_RST;
			cfg_q.increment_scale <= INCREMENT_SCALE_RST;
			cfg_q.min_increment   <= MIN_INCREMENT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WAVE_TYPE:       wave_type_q           <= wave_t'(cfg_data[1:0]);
				REG_ENV_ENABLE:      cfg_q.env_enable      <= cfg_data[0];
				REG_MIN_FREQUENCY:   cfg_q.min_frequency   <= cfg_data[FREQ_W-1:0];
				REG_MAX_FREQUENCY:   cfg_q.max_frequency   <= cfg_data[FREQ_W-1:0];
				REG_INCREMENT_SCALE: cfg_q.increment_scale <= cfg_data[SCALE_W-1:0];
				REG_MIN_INCREMENT:   cfg_q.min_increment   <= cfg_data[MININC_W-1:0];
				default:             ;
			endcase
		end
	end

	wto_exec #(
		.TABLE_BITS (TABLE_BITS),
		.PHASE_BITS (PHASE_BITS)
	) u_exec (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_cmd       (s_axis_tdata[CMD_W-1:0]),
		.in_frequency (s_axis_tdata[CMD_W +: FREQ_W]),
		.in_env_level (s_axis_tdata[CMD_W+FREQ_W +: ENV_W]),
		.idx_valid    (idx_valid),
		.idx_ready    (idx_ready),
		.idx          (idx)
	);

	wto_wave #(
		.TABLE_BITS  (TABLE_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_wave (
		.clk        (clk),
		.arst_n     (arst_n),
		.wave_type  (wave_type_q),
		.idx_valid  (idx_valid),
		.idx_ready  (idx_ready),
		.idx        (idx),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_sample (sample)
	);

	assign m_axis_tdata = OUT_W'(sample);

endmodule

// ----- rtl/core/wto_exec.sv -----
// input register, phase and increment state, and per-command execute stage
module wto_exec import wto_pkg::*; #(
	parameter int TABLE_BITS = TABLE_BITS_DEF,
	parameter int PHASE_BITS = PHASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      in_cmd,
	input  logic [FREQ_W-1:0]     in_frequency,
	input  logic [ENV_W-1:0]      in_env_level,
	output logic                  idx_valid,
	input  logic                  idx_ready,
	output logic [TABLE_BITS-1:0] idx
);

	localparam int FPROD_W = FREQ_W + SCALE_W;
	localparam int FSH_W   = FPROD_W - 8;
	localparam int FCMP_W  = FSH_W + PHASE_BITS;
	localparam int EPROD_W = PHASE_BITS + ENV_W;
	localparam int ICMP_W  = (PHASE_BITS > MININC_W) ? PHASE_BITS : MININC_W;
	localparam longint unsigned INC_RAW =
		(RESET_FREQ_Q8 * longint'(INCREMENT_SCALE_RST)) >> 8;
	localparam logic [PHASE_BITS-1:0] INC_RST =
		((INC_RAW >> PHASE_BITS) != 0) ? {PHASE_BITS{1'b1}} : PHASE_BITS'(INC_RAW);

	logic                  valid_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [FREQ_W-1:0]     frequency_s1;
	logic [ENV_W-1:0]      env_level_s1;
	logic                  valid_s2;
	logic [TABLE_BITS-1:0] idx_s2;
	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] increment_q;

	logic                  s2_free;
	logic                  fire_s1;
	logic                  is_tick;
	logic [FREQ_W-1:0]     f_clamped;
	logic [FPROD_W-1:0]    f_prod;
	logic [FSH_W-1:0]      f_shifted;
	logic [PHASE_BITS-1:0] inc_from_freq;
	logic [EPROD_W-1:0]    env_prod;
	logic [PHASE_BITS-1:0] env_scaled;
	logic [ICMP_W-1:0]     env_ext;
	logic [ICMP_W-1:0]     floor_ext;
	logic [PHASE_BITS-1:0] step;
	logic [PHASE_BITS-1:0] phase_next;

	assign is_tick  = (cmd_s1 == CMD_TICK);
	assign s2_free  = !valid_s2 || idx_ready;
	assign fire_s1  = valid_s1 && (!is_tick || s2_free);
	assign in_ready = !valid_s1 || fire_s1;

	always_comb begin
		priority if (frequency_s1 < cfg.min_frequency) begin
			f_clamped = cfg.min_frequency;
		end else if (frequency_s1 > cfg.max_frequency) begin
			f_clamped = cfg.max_frequency;
		end else begin
			f_clamped = frequency_s1;
		end
		f_prod    = FPROD_W'(f_clamped) * FPROD_W'(cfg.increment_scale);
		f_shifted = f_prod[FPROD_W-1:8];
		if (FCMP_W'(f_shifted) > FCMP_W'({PHASE_BITS{1'b1}})) begin
			inc_from_freq = {PHASE_BITS{1'b1}};
		end else begin
			inc_from_freq = PHASE_BITS'(f_shifted);
		end
	end

	always_comb begin
		env_prod = EPROD_W'(increment_q) * EPROD_W'(env_level_s1);
		if (env_prod[EPROD_W-1]) begin
			env_scaled = {PHASE_BITS{1'b1}};
		end else begin
			env_scaled = env_prod[EPROD_W-2:ENV_W-1];
		end
		env_ext   = ICMP_W'(env_scaled);
		floor_ext = ICMP_W'(cfg.min_increment);
		if (!cfg.env_enable) begin
			step = increment_q;
		end else if (env_ext >= floor_ext) begin
			step = env_scaled;
		end else begin
			step = PHASE_BITS'(floor_ext);
		end
		phase_next = phase_q + step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			phase_q     <= '0;
			increment_q <= INC_RST;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= fire_s1 && is_tick;
			end
			if (fire_s1) begin
				unique case (cmd_s1)
					CMD_TICK:        phase_q     <= phase_next;
					CMD_SET_FREQ:    increment_q <= inc_from_freq;
					CMD_RESET_PHASE: phase_q     <= '0;
					default:         ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1       <= in_cmd;
			frequency_s1 <= in_frequency;
			env_level_s1 <= in_env_level;
		end
		if (fire_s1 && is_tick) begin
			idx_s2 <= phase_next[PHASE_BITS-1 -: TABLE_BITS];
		end
	end

	assign idx_valid = valid_s2;
	assign idx       = idx_s2;

endmodule

// ----- rtl/core/wto_wave.sv -----
// waveform stage: sine rom, computed shapes and the output register
module wto_wave import wto_pkg::*; #(
	parameter int TABLE_BITS  = TABLE_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wave_t                  wave_type,
	input  logic                   idx_valid,
	output logic                   idx_ready,
	input  logic [TABLE_BITS-1:0]  idx,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [SAMPLE_BITS-1:0] out_sample
);

	localparam int ROM_DEPTH = 2 ** TABLE_BITS;
	localparam int QUARTER   = 2 ** (TABLE_BITS - 2);
	localparam int VW        = SAMPLE_BITS + 3;
	localparam int RW        = TABLE_BITS + SAMPLE_BITS + 2;
	localparam logic signed [VW-1:0] FS     = VW'(longint'(1) << (SAMPLE_BITS - 1));
	localparam logic signed [VW-1:0] FS_MAX = FS - VW'(1);

	typedef logic signed [SAMPLE_BITS-1:0] rom_t [ROM_DEPTH];

	function automatic rom_t build_rom();
		rom_t   rom;
		longint m;
		int     q;
		int     r;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			q = i >> (TABLE_BITS - 2);
			r = i & (QUARTER - 1);
			m = quarter_sine(longint'((q % 2 == 1) ? QUARTER - r : r), TABLE_BITS,
				SAMPLE_BITS);
			if (q < 2) begin
				rom[i] = SAMPLE_BITS'((m > longint'(FS_MAX)) ? longint'(FS_MAX) : m);
			end else begin
				rom[i] = SAMPLE_BITS'(-m);
			end
		end
		return rom;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic                   valid_q;
	logic [SAMPLE_BITS-1:0] sample_q;
	logic [RW-1:0]          ramp_up;
	logic [RW-1:0]          ramp_down;
	logic [RW-1:0]          ramp_saw;
	logic signed [VW-1:0]   shape;
	logic signed [VW-1:0]   shape_sat;

	assign idx_ready = !valid_q || out_ready;

	always_comb begin
		ramp_up   = (RW'(idx) << (SAMPLE_BITS + 1)) >> TABLE_BITS;
		ramp_down = (RW'({1'b0, idx[TABLE_BITS-2:0]}) << (SAMPLE_BITS + 1)) >> TABLE_BITS;
		ramp_saw  = (RW'(idx) << SAMPLE_BITS) >> TABLE_BITS;
		unique case (wave_type)
			WAVE_TRIANGLE: begin
				if (!idx[TABLE_BITS-1]) begin
					shape = -FS + $signed(VW'(ramp_up));
				end else begin
					shape = FS - $signed(VW'(ramp_down));
				end
			end
			WAVE_SAW:    shape = -FS + $signed(VW'(ramp_saw));
			WAVE_SQUARE: shape = idx[TABLE_BITS-1] ? -FS : FS;
			default:     shape = '0;
		endcase
		shape_sat = (shape > FS_MAX) ? FS_MAX : shape;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (idx_ready) begin
			valid_q <= idx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (idx_ready && idx_valid) begin
			if (wave_type == WAVE_SINE) begin
				sample_q <= SINE_ROM[idx];
			end else begin
				sample_q <= shape_sat[SAMPLE_BITS-1:0];
			end
		end
	end

	assign out_valid  = valid_q;
	assign out_sample = sample_q;

endmodule

// ----- rtl/core/wto_checker.sv -----
// port-level checks for the wavetable oscillator, bound to the top level
module wto_checker import wto_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tvalid,
	input logic                             s_axis_tready,
	input logic [S_TDATA_W-1:0]             s_axis_tdata,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata
);

	logic [2:0] pending_q;
	logic       tick_in;
	logic       sample_out;

	assign tick_in    = s_axis_tvalid && s_axis_tready && (s_axis_tdata[CMD_W-1:0] == CMD_TICK);
	assign sample_out = m_axis_tvalid && m_axis_tready;

	// ticks taken whose sample is not yet out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(tick_in) - 3'(sample_out);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");

	a_out_has_tick: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> pending_q != 3'd0)
		else $error("sample without a tick");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd3)
		else $error("more ticks in flight than stages");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output backpressure");

endmodule

bind wavetable_oscillator_core wto_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_wto_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
